// ===== hw/rtl/bmtd_pkg.sv =====
// Shared types, token codes and marker constants for the Bolt message token decoder.
`default_nettype none

package bmtd_pkg;

  // Token kinds on the result channel
  localparam logic [3:0] TK_NULL       = 4'd0;
  localparam logic [3:0] TK_BOOL       = 4'd1;
  localparam logic [3:0] TK_INT        = 4'd2;
  localparam logic [3:0] TK_FLOAT      = 4'd3;
  localparam logic [3:0] TK_STR        = 4'd4;
  localparam logic [3:0] TK_BYTES      = 4'd5;
  localparam logic [3:0] TK_LIST       = 4'd6;
  localparam logic [3:0] TK_MAP        = 4'd7;
  localparam logic [3:0] TK_STRUCT     = 4'd8;
  localparam logic [3:0] TK_CONTENT    = 4'd9;
  localparam logic [3:0] TK_END        = 4'd10;
  localparam logic [3:0] TK_ERR_START  = 4'd11;
  localparam logic [3:0] TK_ERR_MARKER = 4'd12;
  localparam logic [3:0] TK_ERR_TRUNC  = 4'd13;

  // What a multi-byte collection is building
  localparam logic [3:0] PK_NONE   = 4'd0;
  localparam logic [3:0] PK_I8     = 4'd1;
  localparam logic [3:0] PK_I16    = 4'd2;
  localparam logic [3:0] PK_I32    = 4'd3;
  localparam logic [3:0] PK_I64    = 4'd4;
  localparam logic [3:0] PK_FLOAT  = 4'd5;
  localparam logic [3:0] PK_STR    = 4'd6;
  localparam logic [3:0] PK_BYTES  = 4'd7;
  localparam logic [3:0] PK_LIST   = 4'd8;
  localparam logic [3:0] PK_MAP    = 4'd9;
  localparam logic [3:0] PK_STRUCT = 4'd10;

  // PackStream markers
  localparam logic [7:0] MK_TINY_INT_MAX = 8'h7F;
  localparam logic [7:0] MK_NEG_INT_MIN  = 8'hF0;
  localparam logic [3:0] MK_TINY_STR     = 4'h8;
  localparam logic [3:0] MK_TINY_LIST    = 4'h9;
  localparam logic [3:0] MK_TINY_MAP     = 4'hA;
  localparam logic [3:0] MK_TINY_STRUCT  = 4'hB;
  localparam logic [7:0] MK_NULL     = 8'hC0;
  localparam logic [7:0] MK_FLOAT64  = 8'hC1;
  localparam logic [7:0] MK_FALSE    = 8'hC2;
  localparam logic [7:0] MK_TRUE     = 8'hC3;
  localparam logic [7:0] MK_INT8     = 8'hC8;
  localparam logic [7:0] MK_INT16    = 8'hC9;
  localparam logic [7:0] MK_INT32    = 8'hCA;
  localparam logic [7:0] MK_INT64    = 8'hCB;
  localparam logic [7:0] MK_BYTES8   = 8'hCC;
  localparam logic [7:0] MK_BYTES16  = 8'hCD;
  localparam logic [7:0] MK_BYTES32  = 8'hCE;
  localparam logic [7:0] MK_STRING8  = 8'hD0;
  localparam logic [7:0] MK_STRING16 = 8'hD1;
  localparam logic [7:0] MK_STRING32 = 8'hD2;
  localparam logic [7:0] MK_LIST8    = 8'hD4;
  localparam logic [7:0] MK_LIST16   = 8'hD5;
  localparam logic [7:0] MK_LIST32   = 8'hD6;
  localparam logic [7:0] MK_MAP8     = 8'hD8;
  localparam logic [7:0] MK_MAP16    = 8'hD9;
  localparam logic [7:0] MK_MAP32    = 8'hDA;
  localparam logic [7:0] MK_STRUCT8  = 8'hDC;
  localparam logic [7:0] MK_STRUCT16 = 8'hDD;

  localparam logic [31:0] LEN_SAT = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CP_HIGH = 3'b001,
    CP_LOW  = 3'b010,
    CP_BODY = 3'b100
  } chunk_phase_t;

  typedef enum logic [3:0] {
    TP_MARKER  = 4'b0001,
    TP_COLLECT = 4'b0010,
    TP_TAG     = 4'b0100,
    TP_CONTENT = 4'b1000
  } token_phase_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [63:0] value;
    logic [7:0]         tag;
    logic               hdr;
  } token_t;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bmtd_if.sv =====
// Valid/ready channel interfaces for wire bytes and decoded tokens.
`default_nettype none

interface bmtd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_byte;

  modport source (output valid, output wire_byte, input ready);
  modport sink   (input valid, input wire_byte, output ready);
endinterface

interface bmtd_token_if;
  logic               valid;
  logic               ready;
  logic [3:0]         token_kind;
  logic signed [63:0] token_value;
  logic [7:0]         struct_tag;
  logic               is_message_header;

  modport source (output valid, output token_kind, output token_value,
                  output struct_tag, output is_message_header, input ready);
  modport sink   (input valid, input token_kind, input token_value,
                  input struct_tag, input is_message_header, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bmtd_core.sv =====
// Framing and tokenizer state with its combinational per-byte update.
`default_nettype none

module bmtd_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       wire_byte,
  output bmtd_pkg::result_t     res
);
  import bmtd_pkg::*;

  chunk_phase_t chunk_phase, chunk_phase_next;
  token_phase_t token_phase, token_phase_next;
  logic [15:0]  chunk_remaining, chunk_remaining_next;
  logic [31:0]  message_length, message_length_next;
  logic [3:0]   bytes_to_collect, bytes_to_collect_next;
  logic [3:0]   pending_kind, pending_kind_next;
  logic [63:0]  accumulator, accumulator_next;
  logic [31:0]  content_remaining, content_remaining_next;
  logic [15:0]  struct_field_count, struct_field_count_next;
  logic         skipping_message, skipping_message_next;

  logic [63:0]  acc_shift;
  logic [15:0]  chunk_len;
  logic [7:0]   b;

  assign b         = wire_byte;
  assign acc_shift = {accumulator[55:0], b};
  assign chunk_len = {chunk_remaining[7:0], b};

  always_comb begin
    chunk_phase_next        = chunk_phase;
    token_phase_next        = token_phase;
    chunk_remaining_next    = chunk_remaining;
    message_length_next     = message_length;
    bytes_to_collect_next   = bytes_to_collect;
    pending_kind_next       = pending_kind;
    accumulator_next        = accumulator;
    content_remaining_next  = content_remaining;
    struct_field_count_next = struct_field_count;
    skipping_message_next   = skipping_message;
    res                     = '0;

    case (chunk_phase)
      CP_BODY: begin
        if (!skipping_message) begin
          if (message_length == 32'd0) begin
            if (b[7:4] == MK_TINY_STRUCT) begin
              struct_field_count_next = {12'd0, b[3:0]};
              token_phase_next        = TP_TAG;
            end else begin
              skipping_message_next = 1'b1;
              res.valid             = 1'b1;
              res.tok.kind          = TK_ERR_START;
              res.tok.value         = {56'd0, b};
            end
          end else begin
            case (token_phase)
              TP_COLLECT: begin
                accumulator_next = acc_shift;
                if (bytes_to_collect <= 4'd1) begin
                  bytes_to_collect_next = 4'd0;
                  token_phase_next      = TP_MARKER;
                  res.valid             = 1'b1;
                  case (pending_kind)
                    PK_I8: begin
                      res.tok.kind  = TK_INT;
                      res.tok.value = {{56{acc_shift[7]}}, acc_shift[7:0]};
                    end
                    PK_I16: begin
                      res.tok.kind  = TK_INT;
                      res.tok.value = {{48{acc_shift[15]}}, acc_shift[15:0]};
                    end
                    PK_I32: begin
                      res.tok.kind  = TK_INT;
                      res.tok.value = {{32{acc_shift[31]}}, acc_shift[31:0]};
                    end
                    PK_I64: begin
                      res.tok.kind  = TK_INT;
                      res.tok.value = acc_shift;
                    end
                    PK_FLOAT: begin
                      res.tok.kind  = TK_FLOAT;
                      res.tok.value = acc_shift;
                    end
                    PK_STR, PK_BYTES: begin
                      res.tok.kind  = (pending_kind == PK_STR) ? TK_STR : TK_BYTES;
                      res.tok.value = {32'd0, acc_shift[31:0]};
                      content_remaining_next = acc_shift[31:0];
                      token_phase_next = (acc_shift[31:0] != 32'd0) ? TP_CONTENT
                                                                     : TP_MARKER;
                    end
                    PK_LIST, PK_MAP: begin
                      res.tok.kind  = (pending_kind == PK_LIST) ? TK_LIST : TK_MAP;
                      res.tok.value = {32'd0, acc_shift[31:0]};
                    end
                    PK_STRUCT: begin
                      res.valid               = 1'b0;
                      struct_field_count_next = acc_shift[15:0];
                      token_phase_next        = TP_TAG;
                    end
                    default: begin
                      res.valid = 1'b0;
                    end
                  endcase
                end else begin
                  bytes_to_collect_next = bytes_to_collect - 4'd1;
                end
              end
              TP_TAG: begin
                token_phase_next = TP_MARKER;
                res.valid        = 1'b1;
                res.tok.kind     = TK_STRUCT;
                res.tok.value    = {48'd0, struct_field_count};
                res.tok.tag      = b;
                res.tok.hdr      = (message_length == 32'd1);
              end
              TP_CONTENT: begin
                if (content_remaining <= 32'd1) begin
                  content_remaining_next = 32'd0;
                  token_phase_next       = TP_MARKER;
                end else begin
                  content_remaining_next = content_remaining - 32'd1;
                end
                res.valid     = 1'b1;
                res.tok.kind  = TK_CONTENT;
                res.tok.value = {56'd0, b};
              end
              default: begin
                // Marker byte: decode the token head
                if (b <= MK_TINY_INT_MAX) begin
                  res.valid     = 1'b1;
                  res.tok.kind  = TK_INT;
                  res.tok.value = {56'd0, b};
                end else if (b >= MK_NEG_INT_MIN) begin
                  res.valid     = 1'b1;
                  res.tok.kind  = TK_INT;
                  res.tok.value = {{56{1'b1}}, b};
                end else if (b[7:4] == MK_TINY_STR) begin
                  res.valid              = 1'b1;
                  res.tok.kind           = TK_STR;
                  res.tok.value          = {60'd0, b[3:0]};
                  content_remaining_next = {28'd0, b[3:0]};
                  token_phase_next = (b[3:0] != 4'd0) ? TP_CONTENT : TP_MARKER;
                end else if (b[7:4] == MK_TINY_LIST) begin
                  res.valid     = 1'b1;
                  res.tok.kind  = TK_LIST;
                  res.tok.value = {60'd0, b[3:0]};
                end else if (b[7:4] == MK_TINY_MAP) begin
                  res.valid     = 1'b1;
                  res.tok.kind  = TK_MAP;
                  res.tok.value = {60'd0, b[3:0]};
                end else if (b[7:4] == MK_TINY_STRUCT) begin
                  struct_field_count_next = {12'd0, b[3:0]};
                  token_phase_next        = TP_TAG;
                end else begin
                  accumulator_next = 64'd0;
                  token_phase_next = TP_COLLECT;
                  case (b)
                    MK_NULL: begin
                      token_phase_next = TP_MARKER;
                      accumulator_next = accumulator;
                      res.valid        = 1'b1;
                      res.tok.kind     = TK_NULL;
                    end
                    MK_FALSE, MK_TRUE: begin
                      token_phase_next = TP_MARKER;
                      accumulator_next = accumulator;
                      res.valid        = 1'b1;
                      res.tok.kind     = TK_BOOL;
                      res.tok.value    = {63'd0, b[0]};
                    end
                    MK_FLOAT64: begin
                      pending_kind_next = PK_FLOAT; bytes_to_collect_next = 4'd8;
                    end
                    MK_INT8: begin
                      pending_kind_next = PK_I8; bytes_to_collect_next = 4'd1;
                    end
                    MK_INT16: begin
                      pending_kind_next = PK_I16; bytes_to_collect_next = 4'd2;
                    end
                    MK_INT32: begin
                      pending_kind_next = PK_I32; bytes_to_collect_next = 4'd4;
                    end
                    MK_INT64: begin
                      pending_kind_next = PK_I64; bytes_to_collect_next = 4'd8;
                    end
                    MK_BYTES8: begin
                      pending_kind_next = PK_BYTES; bytes_to_collect_next = 4'd1;
                    end
                    MK_BYTES16: begin
                      pending_kind_next = PK_BYTES; bytes_to_collect_next = 4'd2;
                    end
                    MK_BYTES32: begin
                      pending_kind_next = PK_BYTES; bytes_to_collect_next = 4'd4;
                    end
                    MK_STRING8: begin
                      pending_kind_next = PK_STR; bytes_to_collect_next = 4'd1;
                    end
                    MK_STRING16: begin
                      pending_kind_next = PK_STR; bytes_to_collect_next = 4'd2;
                    end
                    MK_STRING32: begin
                      pending_kind_next = PK_STR; bytes_to_collect_next = 4'd4;
                    end
                    MK_LIST8: begin
                      pending_kind_next = PK_LIST; bytes_to_collect_next = 4'd1;
                    end
                    MK_LIST16: begin
                      pending_kind_next = PK_LIST; bytes_to_collect_next = 4'd2;
                    end
                    MK_LIST32: begin
                      pending_kind_next = PK_LIST; bytes_to_collect_next = 4'd4;
                    end
                    MK_MAP8: begin
                      pending_kind_next = PK_MAP; bytes_to_collect_next = 4'd1;
                    end
                    MK_MAP16: begin
                      pending_kind_next = PK_MAP; bytes_to_collect_next = 4'd2;
                    end
                    MK_MAP32: begin
                      pending_kind_next = PK_MAP; bytes_to_collect_next = 4'd4;
                    end
                    MK_STRUCT8: begin
                      pending_kind_next = PK_STRUCT; bytes_to_collect_next = 4'd1;
                    end
                    MK_STRUCT16: begin
                      pending_kind_next = PK_STRUCT; bytes_to_collect_next = 4'd2;
                    end
                    default: begin
                      // Unknown marker: report it and skip the message
                      token_phase_next      = TP_MARKER;
                      accumulator_next      = accumulator;
                      skipping_message_next = 1'b1;
                      res.valid             = 1'b1;
                      res.tok.kind          = TK_ERR_MARKER;
                      res.tok.value         = {56'd0, b};
                    end
                  endcase
                end
              end
            endcase
          end
        end

        if (message_length != LEN_SAT) begin
          message_length_next = message_length + 32'd1;
        end
        if (chunk_remaining <= 16'd1) begin
          chunk_remaining_next = 16'd0;
          chunk_phase_next     = CP_HIGH;
        end else begin
          chunk_remaining_next = chunk_remaining - 16'd1;
        end
      end
      CP_LOW: begin
        if (chunk_len == 16'd0) begin
          res.valid     = 1'b1;
          res.tok.kind  = TK_END;
          res.tok.value = {32'd0, message_length};
          if (!skipping_message) begin
            if (message_length < 32'd2) begin
              res.tok.kind = TK_ERR_START;
            end else if (token_phase == TP_COLLECT || token_phase == TP_TAG ||
                         token_phase == TP_CONTENT) begin
              res.tok.kind = TK_ERR_TRUNC;
            end
          end
          message_length_next     = 32'd0;
          token_phase_next        = TP_MARKER;
          bytes_to_collect_next   = 4'd0;
          pending_kind_next       = PK_NONE;
          accumulator_next        = 64'd0;
          content_remaining_next  = 32'd0;
          struct_field_count_next = 16'd0;
          skipping_message_next   = 1'b0;
          chunk_phase_next        = CP_HIGH;
          chunk_remaining_next    = 16'd0;
        end else begin
          chunk_remaining_next = chunk_len;
          chunk_phase_next     = CP_BODY;
        end
      end
      default: begin
        chunk_remaining_next = {8'd0, b};
        chunk_phase_next     = CP_LOW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_phase        <= CP_HIGH;
      token_phase        <= TP_MARKER;
      chunk_remaining    <= '0;
      message_length     <= '0;
      bytes_to_collect   <= '0;
      pending_kind       <= PK_NONE;
      accumulator        <= '0;
      content_remaining  <= '0;
      struct_field_count <= '0;
      skipping_message   <= 1'b0;
    end else if (step) begin
      chunk_phase        <= chunk_phase_next;
      token_phase        <= token_phase_next;
      chunk_remaining    <= chunk_remaining_next;
      message_length     <= message_length_next;
      bytes_to_collect   <= bytes_to_collect_next;
      pending_kind       <= pending_kind_next;
      accumulator        <= accumulator_next;
      content_remaining  <= content_remaining_next;
      struct_field_count <= struct_field_count_next;
      skipping_message   <= skipping_message_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bolt_message_token_decoder_top.sv =====
// Top level of the Bolt message token decoder: input register, decoder core, result register.
// Path: an accepted byte waits in the input register; the core decodes it and any
//   token goes to the result register, which must be free or being emptied.
// Throughput: one byte per cycle while the result side is ready; a stall holds the input.
// Reset: synchronous, active high; clears framing and token state and both
//   valid flags, so no token is shown until the first one has been decoded.
`default_nettype none

module bolt_message_token_decoder_top (
  input  wire logic    clk,
  input  wire logic    rst,
  bmtd_byte_if.sink    rx,
  bmtd_token_if.source tokens
);
  import bmtd_pkg::*;

  // Input register: holds one byte until the core can consume it
  logic       byte_valid;
  logic [7:0] byte_held;

  // Result register
  logic       out_valid;
  token_t     out_tok;

  result_t    res;
  logic       step;

  // Advance the core when a byte is held and the result slot is free or
  // being emptied by a transfer in this cycle.
  assign step     = byte_valid && (!out_valid || tokens.ready);
  assign rx.ready = !byte_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.ready) begin
      byte_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      byte_held <= rx.wire_byte;
    end
  end

  bmtd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .wire_byte (byte_held),
    .res       (res)
  );

  // Load the token when the core steps; drop the valid flag once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res.valid;
    end else if (tokens.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_tok <= res.tok;
    end
  end

  assign tokens.valid             = out_valid;
  assign tokens.token_kind        = out_tok.kind;
  assign tokens.token_value       = out_tok.value;
  assign tokens.struct_tag        = out_tok.tag;
  assign tokens.is_message_header = out_tok.hdr;

endmodule

`default_nettype wire

// ===== hw/rtl/bmtd_checker.sv =====
// Port-level checker for the Bolt message token decoder, with its bind.
`default_nettype none

module bmtd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        tok_valid,
  input wire logic        tok_ready,
  input wire logic [3:0]  token_kind,
  input wire logic [63:0] token_value,
  input wire logic [7:0]  struct_tag,
  input wire logic        is_message_header
);
  import bmtd_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid && $stable(token_kind) &&
      $stable(token_value) && $stable(struct_tag) && $stable(is_message_header))
    else $error("token changed while stalled");

  a_no_token_after_reset: assert property (@(posedge clk)
    rst |=> !tok_valid)
    else $error("token shown straight after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> token_kind <= TK_ERR_TRUNC)
    else $error("token kind out of range");

  a_tag_only_struct: assert property (@(posedge clk) disable iff (rst)
    tok_valid && token_kind != TK_STRUCT |-> struct_tag == 8'd0 && !is_message_header)
    else $error("tag or header flag on a non-struct token");

  a_content_byte: assert property (@(posedge clk) disable iff (rst)
    tok_valid && (token_kind == TK_CONTENT || token_kind == TK_ERR_MARKER) |->
      token_value[63:8] == 56'd0)
    else $error("content or marker value wider than a byte");

endmodule

bind bolt_message_token_decoder_top bmtd_checker u_bmtd_checker (
  .clk               (clk),
  .rst               (rst),
  .tok_valid         (tokens.valid),
  .tok_ready         (tokens.ready),
  .token_kind        (tokens.token_kind),
  .token_value       (tokens.token_value),
  .struct_tag        (tokens.struct_tag),
  .is_message_header (tokens.is_message_header)
);

`default_nettype wire
